@@ hw/rtl/vde_pkg.sv @@
`timescale 1ns / 1ps
// vde_pkg: constants, types and state encodings for the vector distance engine.
// No dependencies; used by every other file of the block.
package vde_pkg;

    localparam int LANES      = 8;
    localparam int ELEM_W     = 8;
    localparam int WORD_W     = 64;
    localparam int NLANE_W    = 4;
    localparam int LPROD_W    = 16;
    localparam int ACC_W      = 29;
    localparam int DIST_W     = 28;
    localparam int Q_W        = 17;
    localparam int PADDR_W    = 3;

    localparam logic [ACC_W-1:0]  ACC_CEIL = {ACC_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
    localparam logic [Q_W-1:0]    Q_ONE    = 17'd65536;

    localparam logic REG_METRIC = 1'b0;
    localparam logic REG_SIGNED = 1'b1;

    localparam logic MODE_L2     = 1'b0;
    localparam logic MODE_COSINE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LANE,
        S_ACC,
        S_FIN,
        S_COS,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        C_IDLE,
        C_SQ,
        C_ML,
        C_MH,
        C_CMP
    } t_cos_state;

    typedef struct packed {
        logic [LPROD_W-1:0] sq;
        logic [LPROD_W-1:0] dp;
        logic [LPROD_W-1:0] na;
        logic [LPROD_W-1:0] nb;
    } t_lane_res;

    typedef struct packed {
        logic [ACC_W-1:0] sq;
        logic [ACC_W-1:0] dp;
        logic [ACC_W-1:0] na;
        logic [ACC_W-1:0] nb;
        logic             sat_seen;
    } t_acc;

endpackage

@@ hw/rtl/vde_if.sv @@
`timescale 1ns / 1ps
// vde_in_if / vde_out_if: valid-ready channels of the vector distance engine.
// Depends on vde_pkg for field widths.
interface vde_in_if;
    logic                             valid;
    logic                             ready;
    logic [vde_pkg::WORD_W-1:0]       vec_a_bytes;
    logic [vde_pkg::WORD_W-1:0]       vec_b_bytes;
    logic [vde_pkg::NLANE_W-1:0]      lanes_valid;
    logic                             last_beat;

    modport source (output valid, vec_a_bytes, vec_b_bytes, lanes_valid, last_beat,
                    input ready);
    modport sink   (input valid, vec_a_bytes, vec_b_bytes, lanes_valid, last_beat,
                    output ready);
endinterface

interface vde_out_if;
    logic                             valid;
    logic                             ready;
    logic [vde_pkg::DIST_W-1:0]       distance;
    logic                             zero_norm;
    logic                             saturated;

    modport source (output valid, distance, zero_norm, saturated, input ready);
    modport sink   (input valid, distance, zero_norm, saturated, output ready);
endinterface

@@ hw/rtl/vde_lane.sv @@
`timescale 1ns / 1ps
// vde_lane: one element pair -> squared difference, dot term and both norm terms.
// Depends on vde_pkg.
module vde_lane (
    input  logic                          i_clk,
    input  logic                          i_load,
    input  logic                          i_active,
    input  logic                          i_signed,
    input  logic [vde_pkg::ELEM_W-1:0]    i_a,
    input  logic [vde_pkg::ELEM_W-1:0]    i_b,
    output vde_pkg::t_lane_res            o_res
);

    logic signed [8:0]  sa;
    logic signed [8:0]  sb;
    logic signed [9:0]  d;
    logic signed [19:0] dsq;
    vde_pkg::t_lane_res n_res;
    vde_pkg::t_lane_res r_res;

    always_comb begin
        sa    = signed'({i_signed & i_a[7], i_a});
        sb    = signed'({i_signed & i_b[7], i_b});
        d     = 10'(sa) - 10'(sb);
        dsq   = 20'(d) * 20'(d);
        n_res = '0;
        if (i_active) begin
            n_res.sq = dsq[15:0];
            n_res.dp = 16'(i_a) * 16'(i_b);
            n_res.na = 16'(i_a) * 16'(i_a);
            n_res.nb = 16'(i_b) * 16'(i_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

@@ hw/rtl/vde_merge.sv @@
`timescale 1ns / 1ps
// vde_merge: sums the lane terms and folds them into saturating accumulators.
// Depends on vde_pkg and the outputs of vde_lane.
module vde_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_add,
    input  logic                 i_clear,
    input  logic                 i_mode,
    input  vde_pkg::t_lane_res   i_lanes [vde_pkg::LANES],
    output vde_pkg::t_acc        o_acc
);

    localparam int SUM_W = vde_pkg::LPROD_W + $clog2(vde_pkg::LANES + 1);

    logic [SUM_W-1:0] s_sq, s_dp, s_na, s_nb;
    vde_pkg::t_acc    r_acc;
    vde_pkg::t_acc    n_acc;

    function automatic logic [vde_pkg::ACC_W-1:0] sat_add(
        input logic [vde_pkg::ACC_W-1:0] acc,
        input logic [SUM_W-1:0]          v
    );
        logic [vde_pkg::ACC_W:0] s;
        s = {1'b0, acc} + (vde_pkg::ACC_W+1)'(v);
        return s[vde_pkg::ACC_W] ? vde_pkg::ACC_CEIL : s[vde_pkg::ACC_W-1:0];
    endfunction

    always_comb begin
        s_sq = '0;
        s_dp = '0;
        s_na = '0;
        s_nb = '0;
        for (int i = 0; i < vde_pkg::LANES; i++) begin
            s_sq = s_sq + SUM_W'(i_lanes[i].sq);
            s_dp = s_dp + SUM_W'(i_lanes[i].dp);
            s_na = s_na + SUM_W'(i_lanes[i].na);
            s_nb = s_nb + SUM_W'(i_lanes[i].nb);
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_clear) begin
            n_acc = '0;
        end else if (i_add) begin
            n_acc.sq = sat_add(r_acc.sq, s_sq);
            n_acc.dp = sat_add(r_acc.dp, s_dp);
            n_acc.na = sat_add(r_acc.na, s_na);
            n_acc.nb = sat_add(r_acc.nb, s_nb);
            if (i_mode == vde_pkg::MODE_L2) begin
                if (n_acc.sq == vde_pkg::ACC_CEIL) n_acc.sat_seen = 1'b1;
            end else if (n_acc.dp == vde_pkg::ACC_CEIL || n_acc.na == vde_pkg::ACC_CEIL
                         || n_acc.nb == vde_pkg::ACC_CEIL) begin
                n_acc.sat_seen = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

@@ hw/rtl/vde_cosine.sv @@
`timescale 1ns / 1ps
// vde_cosine: bit-serial search for floor(65536*(1-dot/sqrt(na*nb))).
// Depends on vde_pkg. Tests one candidate bit per pass through C_SQ, C_ML, C_MH and C_CMP.
module vde_cosine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [vde_pkg::ACC_W-1:0]      i_dot,
    input  logic [vde_pkg::ACC_W-1:0]      i_na,
    input  logic [vde_pkg::ACC_W-1:0]      i_nb,
    output logic                           o_done,
    output logic [vde_pkg::Q_W-1:0]        o_dist
);

    localparam int AW  = vde_pkg::ACC_W;
    localparam int PW  = 2 * AW;
    localparam int QQW = 2 * vde_pkg::Q_W;
    localparam int PPW = QQW + AW;
    localparam int CW  = PPW + AW;

    vde_pkg::t_cos_state r_cstate, n_cstate;
    logic [4:0]              r_bit;
    logic [vde_pkg::Q_W-1:0] r_t, cand, t_next;
    logic [PW-1:0]           r_prod, r_dsq;
    logic                    r_dot_zero;
    logic [QQW-1:0]          r_qq;
    logic [PPW-1:0]          r_plo, r_phi;
    logic [CW-1:0]           lhs, rhs;
    logic                    reach;
    logic                    r_done;
    logic [vde_pkg::Q_W-1:0] r_dist;

    always_comb begin
        cand   = r_t + (vde_pkg::Q_W'(1) << r_bit);
        lhs    = {r_phi, {AW{1'b0}}} + CW'(r_plo);
        rhs    = CW'({r_dsq, 32'b0});
        reach  = (lhs >= rhs);
        t_next = reach ? r_t : cand;
    end

    always_comb begin
        n_cstate = r_cstate;
        unique case (r_cstate)
            vde_pkg::C_IDLE: if (i_start) n_cstate = vde_pkg::C_SQ;
            vde_pkg::C_SQ:   n_cstate = vde_pkg::C_ML;
            vde_pkg::C_ML:   n_cstate = vde_pkg::C_MH;
            vde_pkg::C_MH:   n_cstate = vde_pkg::C_CMP;
            vde_pkg::C_CMP: begin
                if ((r_bit == 5'd16 && !reach) || r_bit == 5'd0) n_cstate = vde_pkg::C_IDLE;
                else n_cstate = vde_pkg::C_SQ;
            end
            default: n_cstate = vde_pkg::C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cstate <= vde_pkg::C_IDLE;
            r_done   <= 1'b0;
        end else begin
            r_cstate <= n_cstate;
            r_done   <= (r_cstate == vde_pkg::C_CMP) && (n_cstate == vde_pkg::C_IDLE);
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_cstate)
            vde_pkg::C_IDLE: begin
                r_prod     <= {{AW{1'b0}}, i_na} * {{AW{1'b0}}, i_nb};
                r_dsq      <= {{AW{1'b0}}, i_dot} * {{AW{1'b0}}, i_dot};
                r_dot_zero <= (i_dot == '0);
                r_bit      <= 5'd16;
                r_t        <= '0;
            end
            vde_pkg::C_SQ: r_qq  <= QQW'(cand) * QQW'(cand);
            vde_pkg::C_ML: r_plo <= PPW'(r_qq) * PPW'(r_prod[AW-1:0]);
            vde_pkg::C_MH: r_phi <= PPW'(r_qq) * PPW'(r_prod[PW-1:AW]);
            vde_pkg::C_CMP: begin
                r_t   <= t_next;
                r_bit <= r_bit - 5'd1;
                if (r_bit == 5'd16 && !reach) begin
                    r_dist <= '0;
                end else if (r_bit == 5'd0) begin
                    r_dist <= r_dot_zero ? vde_pkg::Q_ONE : vde_pkg::Q_ONE - t_next - 17'd1;
                end
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_dist = r_dist;

endmodule

@@ hw/rtl/vector_distance_engine.sv @@
`timescale 1ns / 1ps
// vector_distance_engine: top level; lanes, merge, cosine finish, output word, APB regs.
// Depends on vde_pkg, vde_if, vde_lane, vde_merge, vde_cosine.
//
//  channel   dir  kind       payload
//  i_in      in   valid/rdy  vec_a_bytes, vec_b_bytes, lanes_valid, last_beat
//  o_out     out  valid/rdy  distance, zero_norm, saturated
//  apb       in   APB r/w    metric_mode @0x0, signed_elements @0x4
//
// Each word passes through capture, lane products and merge. A last word then
// adds a finish step, in cosine mode with nonzero norms the 17-bit search (ended
// after its first bit when the full-scale candidate is accepted), and the load of
// the output register. Reset is synchronous, active low, and clears all
// accumulators. A full output register stalls only a last word.
module vector_distance_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    vde_in_if.sink                          i_in,
    vde_out_if.source                       o_out,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [vde_pkg::PADDR_W-1:0]     i_paddr,
    input  logic [31:0]                     i_pwdata,
    output logic [31:0]                     o_prdata,
    output logic                            o_pready
);

    vde_pkg::t_state r_state, n_state;

    logic r_metric, r_signed;
    logic [vde_pkg::WORD_W-1:0]  r_a, r_b;
    logic [vde_pkg::NLANE_W-1:0] r_n;
    logic r_last;

    vde_pkg::t_lane_res lane_res [vde_pkg::LANES];
    vde_pkg::t_acc      acc;

    logic in_ready, lane_load, acc_add, acc_clear, cos_start, out_load;
    logic out_free, zero_norm_now, cos_done;
    logic [vde_pkg::Q_W-1:0] cos_dist;

    logic                        r_out_valid;
    logic [vde_pkg::DIST_W-1:0]  r_out_dist;
    logic                        r_out_zn, r_out_sat;
    logic [vde_pkg::DIST_W-1:0]  res_dist;
    logic                        res_zn, res_sat;

    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_metric <= 1'b0;
            r_signed <= 1'b0;
        end else if (i_psel && i_penable && i_pwrite) begin
            unique case (i_paddr[2])
                vde_pkg::REG_METRIC: r_metric <= i_pwdata[0];
                vde_pkg::REG_SIGNED: r_signed <= i_pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        o_prdata = '0;
        unique case (i_paddr[2])
            vde_pkg::REG_METRIC: o_prdata[0] = r_metric;
            vde_pkg::REG_SIGNED: o_prdata[0] = r_signed;
            default: ;
        endcase
    end

    assign out_free      = !r_out_valid || o_out.ready;
    assign zero_norm_now = (acc.na == '0) || (acc.nb == '0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vde_pkg::S_IDLE: if (i_in.valid) n_state = vde_pkg::S_LANE;
            vde_pkg::S_LANE: n_state = vde_pkg::S_ACC;
            vde_pkg::S_ACC:  n_state = r_last ? vde_pkg::S_FIN : vde_pkg::S_IDLE;
            vde_pkg::S_FIN: begin
                if (r_metric == vde_pkg::MODE_L2 || zero_norm_now) n_state = vde_pkg::S_EMIT;
                else n_state = vde_pkg::S_COS;
            end
            vde_pkg::S_COS:  if (cos_done) n_state = vde_pkg::S_EMIT;
            vde_pkg::S_EMIT: if (out_free) n_state = vde_pkg::S_IDLE;
            default:         n_state = vde_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = (r_state == vde_pkg::S_IDLE);
        lane_load = (r_state == vde_pkg::S_LANE);
        acc_add   = (r_state == vde_pkg::S_ACC);
        cos_start = (r_state == vde_pkg::S_FIN) && (r_metric == vde_pkg::MODE_COSINE)
                    && !zero_norm_now;
        out_load  = (r_state == vde_pkg::S_EMIT) && out_free;
        acc_clear = out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vde_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (i_in.valid && in_ready) begin
            r_a    <= i_in.vec_a_bytes;
            r_b    <= i_in.vec_b_bytes;
            r_n    <= i_in.lanes_valid;
            r_last <= i_in.last_beat;
        end
    end

    for (genvar g = 0; g < vde_pkg::LANES; g++) begin : g_lane
        vde_lane u_lane (
            .i_clk    (i_clk),
            .i_load   (lane_load),
            .i_active (g < int'(r_n)),
            .i_signed (r_signed),
            .i_a      (r_a[g*vde_pkg::ELEM_W +: vde_pkg::ELEM_W]),
            .i_b      (r_b[g*vde_pkg::ELEM_W +: vde_pkg::ELEM_W]),
            .o_res    (lane_res[g])
        );
    end

    vde_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_add   (acc_add),
        .i_clear (acc_clear),
        .i_mode  (r_metric),
        .i_lanes (lane_res),
        .o_acc   (acc)
    );

    vde_cosine u_cosine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cos_start),
        .i_dot   (acc.dp),
        .i_na    (acc.na),
        .i_nb    (acc.nb),
        .o_done  (cos_done),
        .o_dist  (cos_dist)
    );

    always_comb begin
        res_zn  = 1'b0;
        res_sat = acc.sat_seen;
        if (r_metric == vde_pkg::MODE_L2) begin
            if (acc.sq[vde_pkg::ACC_W-1]) begin
                res_dist = vde_pkg::DIST_MAX;
                res_sat  = 1'b1;
            end else begin
                res_dist = acc.sq[vde_pkg::DIST_W-1:0];
            end
        end else if (zero_norm_now) begin
            res_dist = '0;
            res_zn   = 1'b1;
        end else begin
            res_dist = vde_pkg::DIST_W'(cos_dist);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_dist <= res_dist;
            r_out_zn   <= res_zn;
            r_out_sat  <= res_sat;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.distance  = r_out_dist;
    assign o_out.zero_norm = r_out_zn;
    assign o_out.saturated = r_out_sat;

`ifndef SYNTHESIS
    a_accept_to_lane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_state == vde_pkg::S_LANE)
        else $error("accepted word did not enter lane stage");

    a_cos_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cos_done |-> r_state == vde_pkg::S_COS)
        else $error("cosine unit finished outside its wait state");

    a_zero_norm_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_norm |-> o_out.distance == '0)
        else $error("zero norm word with nonzero distance");

    a_clear_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> acc == '0)
        else $error("accumulators not cleared after result");
`endif

endmodule
